### rtl/sktab_pkg.sv
// sktab_pkg: shared types, codes and field widths of the sorted key table
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package sktab_pkg;

    // default sizing, used as the parameter defaults of the top level and the datapath
    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_BYTES_DEF = 8;

    // fixed field widths of the stream words
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int KEY_FIELD_W = 64;
    localparam int BYTE_W      = 8;
    localparam int SLOT_W      = 7;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 96;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOOKUP     = 3'd0,
        FN_SORTED_INS = 3'd1,
        FN_POS_INS    = 3'd2,
        FN_REMOVE     = 3'd3,
        FN_READ       = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_NOT_FOUND = 3'd1,
        STS_DUPLICATE = 3'd2,
        STS_FULL      = 3'd3,
        STS_BAD_POS   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_POS  = 2'd1,
        RES_DATA = 2'd2
    } t_res_src;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_DISPATCH = 3'd1,
        S_SCAN     = 3'd2,
        S_SCAN_END = 3'd3,
        S_SHIFT_UP = 3'd4,
        S_SHIFT_DN = 3'd5,
        S_RD_WAIT  = 3'd6,
        S_DONE     = 3'd7
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     scan_init;
        logic     scan_step;
        logic     pos_from_slot;
        logic     up_init;
        logic     up_step;
        logic     put;
        logic     dn_init;
        logic     dn_step;
        logic     dn_fin;
        logic     rd_issue;
        logic     set_res;
        t_status  res_status;
        t_res_src res_src;
        logic     push;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              ins_slot_ok;
        logic              slot_ok;
        logic              scan_done;
        logic              key_eq;
        logic              up_done;
        logic              dn_done;
        logic              out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/sktab_ram.sv
// sktab_ram: generic one-write one-read memory with registered read data
// no dependencies
`default_nettype none

module sktab_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/sktab_datapath.sv
// sktab_datapath: operand registers, entry count, scan and shift counters,
// entry memory and output word register; uses sktab_pkg and sktab_ram
`default_nettype none

module sktab_datapath #(
    parameter int CAPACITY  = sktab_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES = sktab_pkg::KEY_BYTES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire sktab_pkg::t_dp_cmd                 i_cmd,
    output sktab_pkg::t_dp_stat                     o_stat,
    input  wire logic [sktab_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  wire logic [sktab_pkg::FUNC_W-1:0]       i_s_tuser,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic      [sktab_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic      [sktab_pkg::STATUS_W-1:0]     o_m_tuser
);

    import sktab_pkg::*;

    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int ENT_W  = KEY_W + 2 * BYTE_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = ((CNT_W > SLOT_W) ? CNT_W : SLOT_W) + 1;

    // bytes after the first zero byte (from the top) read as zero
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_FIELD_W-1:0] k);
        logic [KEY_W-1:0]  r;
        logic              ended;
        logic [BYTE_W-1:0] b;
        r     = '0;
        ended = 1'b0;
        for (int i = KEY_BYTES - 1; i >= 0; i--) begin
            b = k[8*i +: 8];
            if (b == '0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                r[8*i +: 8] = b;
            end
        end
        return r;
    endfunction

    // operand registers
    logic [FUNC_W-1:0] r_func;
    logic [KEY_W-1:0]  r_key;
    logic [BYTE_W-1:0] r_tag;
    logic [BYTE_W-1:0] r_val;
    logic [SLOT_W-1:0] r_slot;

    // count, counters and scan result
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_src;
    logic [CNT_W-1:0]  r_dst;
    logic [CNT_W-1:0]  r_pos;
    logic              r_pv;
    logic              r_eq;

    // finished result, waiting for the output register
    t_status           r_res_status;
    logic [CNT_W-1:0]  r_res_where;
    logic [KEY_W-1:0]  r_res_key;
    logic [BYTE_W-1:0] r_res_tag;
    logic [BYTE_W-1:0] r_res_val;

    // output word
    logic                   r_m_vld;
    logic [STATUS_W-1:0]    r_o_status;
    logic [SLOT_W-1:0]      r_o_where;
    logic [SLOT_W-1:0]      r_o_count;
    logic [KEY_FIELD_W-1:0] r_o_key;
    logic [BYTE_W-1:0]      r_o_tag;
    logic [BYTE_W-1:0]      r_o_val;

    // memory side
    logic             mem_we;
    logic             mem_re;
    logic [CNT_W-1:0] mem_waddr;
    logic [CNT_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [ENT_W-1:0] mem_rdata;

    logic [KEY_W-1:0]  rd_key;
    logic [BYTE_W-1:0] rd_tag;
    logic [BYTE_W-1:0] rd_val;
    logic [CNT_W-1:0]  slot_cnt;
    logic [CNT_W-1:0]  slot_idx;
    logic [CMP_W-1:0]  slot_cmp;
    logic [CMP_W-1:0]  count_cmp;
    logic              hit;

    assign rd_key    = mem_rdata[ENT_W-1:2*BYTE_W];
    assign rd_tag    = mem_rdata[2*BYTE_W-1:BYTE_W];
    assign rd_val    = mem_rdata[BYTE_W-1:0];
    assign slot_cnt  = CNT_W'(r_slot);
    assign slot_idx  = slot_cnt - CNT_W'(1);
    assign slot_cmp  = CMP_W'(r_slot);
    assign count_cmp = CMP_W'(r_count);

    // during a scan, data on the read port is entry r_dst while r_pv is set
    assign hit = r_pv && (rd_key >= r_key);

    always_comb begin
        o_stat.func        = r_func;
        o_stat.full        = (r_count == CNT_W'(CAPACITY));
        o_stat.ins_slot_ok = (slot_cmp != '0) && (slot_cmp <= count_cmp + CMP_W'(1));
        o_stat.slot_ok     = (slot_cmp != '0) && (slot_cmp <= count_cmp);
        o_stat.scan_done   = hit || (!r_pv && (r_src == r_count));
        o_stat.key_eq      = r_eq;
        o_stat.up_done     = !r_pv && (r_src == r_pos);
        o_stat.dn_done     = !r_pv && (r_src == r_count);
        o_stat.out_free    = !r_m_vld || i_m_tready;
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_src;
        if (i_cmd.scan_step && (r_src < r_count)) begin
            mem_re = 1'b1;
        end else if (i_cmd.up_step && (r_src > r_pos)) begin
            mem_re    = 1'b1;
            mem_raddr = r_src - CNT_W'(1);
        end else if (i_cmd.dn_step && (r_src < r_count)) begin
            mem_re = 1'b1;
        end else if (i_cmd.rd_issue) begin
            mem_re    = 1'b1;
            mem_raddr = slot_idx;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_dst;
        mem_wdata = mem_rdata;
        if (i_cmd.put) begin
            mem_we    = 1'b1;
            mem_waddr = r_pos;
            mem_wdata = {r_key, r_tag, r_val};
        end else if ((i_cmd.up_step || i_cmd.dn_step) && r_pv) begin
            // word read last cycle lands one place up or down
            mem_we = 1'b1;
        end
    end

    sktab_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr[ADDR_W-1:0]),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr[ADDR_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pv    <= 1'b0;
            r_m_vld <= 1'b0;
        end else begin
            if (i_cmd.put) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.dn_fin) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.scan_init || i_cmd.up_init || i_cmd.dn_init) begin
                r_pv <= 1'b0;
            end else if (i_cmd.scan_step || i_cmd.up_step || i_cmd.dn_step) begin
                r_pv <= mem_re;
            end
            if (i_cmd.push) begin
                r_m_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_m_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_s_tuser;
            r_key  <= norm_key(i_s_tdata[63:0]);
            r_tag  <= i_s_tdata[71:64];
            r_val  <= i_s_tdata[79:72];
            r_slot <= i_s_tdata[86:80];
        end

        if (i_cmd.scan_init) begin
            r_src <= '0;
        end else if (i_cmd.up_init) begin
            r_src <= r_count;
        end else if (i_cmd.dn_init) begin
            r_src <= slot_cnt;
        end else if (mem_re && i_cmd.scan_step) begin
            r_dst <= r_src;
            r_src <= r_src + CNT_W'(1);
        end else if (mem_re && i_cmd.up_step) begin
            r_dst <= r_src;
            r_src <= r_src - CNT_W'(1);
        end else if (mem_re && i_cmd.dn_step) begin
            r_dst <= r_src - CNT_W'(1);
            r_src <= r_src + CNT_W'(1);
        end

        if (i_cmd.pos_from_slot) begin
            r_pos <= slot_idx;
        end else if (i_cmd.scan_step && o_stat.scan_done) begin
            // first key not below the search key, or the end of the table
            r_pos <= hit ? r_dst : r_count;
            r_eq  <= hit && (rd_key == r_key);
        end

        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_where  <= (i_cmd.res_src == RES_NONE) ? '0 : r_pos + CNT_W'(1);
            if (i_cmd.res_src == RES_DATA) begin
                r_res_key <= rd_key;
                r_res_tag <= rd_tag;
                r_res_val <= rd_val;
            end else begin
                r_res_key <= '0;
                r_res_tag <= '0;
                r_res_val <= '0;
            end
        end

        if (i_cmd.push) begin
            r_o_status <= r_res_status;
            r_o_where  <= SLOT_W'(r_res_where);
            r_o_count  <= SLOT_W'(r_count);
            r_o_key    <= KEY_FIELD_W'(r_res_key);
            r_o_tag    <= r_res_tag;
            r_o_val    <= r_res_val;
        end
    end

    assign o_m_tvalid = r_m_vld;
    assign o_m_tdata  = {2'b00, r_o_val, r_o_tag, r_o_key, r_o_count, r_o_where};
    assign o_m_tuser  = r_o_status;

endmodule

`default_nettype wire

### rtl/sktab_ctrl.sv
// sktab_ctrl: operation sequencer for the sorted key table
// drives datapath commands from its status; uses sktab_pkg
`default_nettype none

module sktab_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire sktab_pkg::t_dp_stat  i_stat,
    output sktab_pkg::t_dp_cmd        o_cmd
);

    import sktab_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_DONE;
                unique case (i_stat.func)
                    FN_LOOKUP: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                    FN_SORTED_INS: begin
                        if (i_stat.full) begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = STS_FULL;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    FN_POS_INS: begin
                        if (i_stat.full) begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = STS_FULL;
                        end else if (!i_stat.ins_slot_ok) begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = STS_BAD_POS;
                        end else begin
                            o_cmd.pos_from_slot = 1'b1;
                            o_cmd.up_init       = 1'b1;
                            n_state             = S_SHIFT_UP;
                        end
                    end
                    FN_REMOVE: begin
                        if (!i_stat.slot_ok) begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = STS_BAD_POS;
                        end else begin
                            o_cmd.pos_from_slot = 1'b1;
                            o_cmd.dn_init       = 1'b1;
                            n_state             = S_SHIFT_DN;
                        end
                    end
                    FN_READ: begin
                        if (!i_stat.slot_ok) begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = STS_BAD_POS;
                        end else begin
                            o_cmd.pos_from_slot = 1'b1;
                            o_cmd.rd_issue      = 1'b1;
                            n_state             = S_RD_WAIT;
                        end
                    end
                    default: begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = STS_BAD_POS;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_DONE;
                if (i_stat.func == FN_LOOKUP) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = i_stat.key_eq ? STS_OK : STS_NOT_FOUND;
                    o_cmd.res_src    = i_stat.key_eq ? RES_POS : RES_NONE;
                end else if (i_stat.key_eq) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = STS_DUPLICATE;
                    o_cmd.res_src    = RES_POS;
                end else begin
                    o_cmd.up_init = 1'b1;
                    n_state       = S_SHIFT_UP;
                end
            end
            S_SHIFT_UP: begin
                o_cmd.up_step = 1'b1;
                if (i_stat.up_done) begin
                    o_cmd.put        = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = STS_OK;
                    o_cmd.res_src    = RES_POS;
                    n_state          = S_DONE;
                end
            end
            S_SHIFT_DN: begin
                o_cmd.dn_step = 1'b1;
                if (i_stat.dn_done) begin
                    o_cmd.dn_fin     = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = STS_OK;
                    o_cmd.res_src    = RES_POS;
                    n_state          = S_DONE;
                end
            end
            S_RD_WAIT: begin
                o_cmd.set_res    = 1'b1;
                o_cmd.res_status = STS_OK;
                o_cmd.res_src    = RES_DATA;
                n_state          = S_DONE;
            end
            S_DONE: begin
                // hand the result over once the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sorted_key_table.sv
// sorted_key_table: top level, sequencer plus datapath with entry memory
// uses sktab_pkg, sktab_ctrl, sktab_datapath and sktab_ram
//
//  channel  | direction | tdata (low bit up)                              | tuser
//  ---------+-----------+-------------------------------------------------+--------
//  s_axis   | in        | key[63:0] tag[71:64] value[79:72] slot[86:80]   | func
//  m_axis   | out       | found_slot entry_count key_out tag_out value_out| status
//
// one word at a time; lookups and sorted inserts scan the entries, inserts and
// removes shift the entries behind the slot, reads and refused words do neither;
// the next word is accepted once the result goes to the output register
// reset clears the entry count and the handshake state; no memory sweep
// a new word is taken while the previous result waits in the output register
`default_nettype none

module sorted_key_table #(
    parameter int CAPACITY  = sktab_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES = sktab_pkg::KEY_BYTES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // key, tag_in, value_in, slot
    input  wire logic [sktab_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // func
    input  wire logic [sktab_pkg::FUNC_W-1:0]       i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // found_slot, entry_count, key_out, tag_out, value_out
    output logic      [sktab_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // status
    output logic      [sktab_pkg::STATUS_W-1:0]     o_m_axis_tuser
);

    import sktab_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sktab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sktab_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_BYTES (KEY_BYTES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

### tb/sorted_key_table_test.sv
// sorted_key_table_test: self-checking bench for the sorted key table, directed
// operations followed by weighted random traffic under varying stream backpressure
// depends on sktab_pkg and sorted_key_table
`timescale 1ns / 1ps

module sorted_key_table_test;

    import sktab_pkg::*;

    localparam int DEPTH       = CAPACITY_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam logic [63:0] KEY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    // function codes the block does not implement
    localparam logic [FUNC_W-1:0] FN_BAD_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_BAD_HI = 3'd7;

    typedef enum int {MIX_GROW, MIX_CHURN, MIX_SHRINK} t_mix;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [63:0]       key;
        logic [7:0]        tag;
        logic [7:0]        value;
        logic [6:0]        slot;
    } t_table_op;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [6:0]          found;
        logic [6:0]          count;
        logic [63:0]         key;
        logic [7:0]          tag;
        logic [7:0]          value;
    } t_table_res;

    typedef struct {
        t_table_op  op;
        bit         typed;
        t_table_res res;
    } t_dir_row;

    typedef struct {
        int   items;
        int   src_idle;
        int   sink_stall;
        t_mix mix;
        bit   long_hold;
    } t_phase;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic [FUNC_W-1:0]       s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]     m_tuser;

    // shadow copy of the table contents
    logic [63:0] shadow_keys[DEPTH];
    logic [7:0]  shadow_tags[DEPTH];
    logic [7:0]  shadow_values[DEPTH];
    int          shadow_fill = 0;

    t_table_res  awaited_results[$];
    t_dir_row    dir_table[$];
    int          mismatches = 0;
    int          words_checked = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    t_func func_order[5] = '{FN_LOOKUP, FN_SORTED_INS, FN_POS_INS, FN_REMOVE, FN_READ};
    // cumulative weights of lookup, sorted insert, positional insert, remove, read
    int op_cut[3][5] = '{'{15, 60, 80, 87, 96}, '{25, 45, 55, 75, 95},
                         '{15, 25, 30, 80, 96}};

    sorted_key_table dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH word %0d %s: got %0h want %0h", words_checked, what, got, want);
        mismatches++;
    endtask

    function automatic int first_not_below(input logic [63:0] k);
        for (int i = 0; i < shadow_fill; i++)
            if (shadow_keys[i] >= k) return i;
        return shadow_fill;
    endfunction

    task automatic place_entry(input int idx, input logic [63:0] k, input logic [7:0] t,
                               input logic [7:0] v);
        for (int i = shadow_fill; i > idx; i--) begin
            shadow_keys[i]   = shadow_keys[i-1];
            shadow_tags[i]   = shadow_tags[i-1];
            shadow_values[i] = shadow_values[i-1];
        end
        shadow_keys[idx]   = k;
        shadow_tags[idx]   = t;
        shadow_values[idx] = v;
        shadow_fill++;
    endtask

    // applies one operation to the shadow table and returns the word it yields
    task automatic apply_table_op(input t_table_op op, output t_table_res res);
        logic [63:0] k;
        logic        ended;
        int          idx;
        // a key string ends at its first zero byte from the top
        k = '0;
        ended = 1'b0;
        for (int b = 7; b >= 0; b--) begin
            if (op.key[8*b +: 8] == 8'h00) ended = 1'b1;
            if (!ended) k[8*b +: 8] = op.key[8*b +: 8];
        end
        res = '0;
        res.status = STS_BAD_POS;
        case (op.func)
            FN_LOOKUP: begin
                idx = first_not_below(k);
                if (idx < shadow_fill && shadow_keys[idx] == k) begin
                    res.status = STS_OK;
                    res.found = 7'(idx + 1);
                end else begin
                    res.status = STS_NOT_FOUND;
                end
            end
            FN_SORTED_INS: begin
                idx = first_not_below(k);
                if (shadow_fill >= DEPTH) begin
                    res.status = STS_FULL;
                end else if (idx < shadow_fill && shadow_keys[idx] == k) begin
                    res.status = STS_DUPLICATE;
                    res.found = 7'(idx + 1);
                end else begin
                    place_entry(idx, k, op.tag, op.value);
                    res.status = STS_OK;
                    res.found = 7'(idx + 1);
                end
            end
            FN_POS_INS: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = STS_FULL;
                end else if (op.slot != 0 && op.slot <= shadow_fill + 1) begin
                    place_entry(op.slot - 1, k, op.tag, op.value);
                    res.status = STS_OK;
                    res.found = op.slot;
                end
            end
            FN_REMOVE: begin
                if (op.slot != 0 && op.slot <= shadow_fill) begin
                    for (int i = op.slot - 1; i + 1 < shadow_fill; i++) begin
                        shadow_keys[i]   = shadow_keys[i+1];
                        shadow_tags[i]   = shadow_tags[i+1];
                        shadow_values[i] = shadow_values[i+1];
                    end
                    shadow_fill--;
                    res.status = STS_OK;
                    res.found = op.slot;
                end
            end
            FN_READ: begin
                if (op.slot != 0 && op.slot <= shadow_fill) begin
                    res.status = STS_OK;
                    res.found = op.slot;
                    res.key   = shadow_keys[op.slot-1];
                    res.tag   = shadow_tags[op.slot-1];
                    res.value = shadow_values[op.slot-1];
                end
            end
            default: ;
        endcase
        res.count = 7'(shadow_fill);
    endtask

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        logic        ended;
        int          r;
        int          len;
        r = $urandom_range(99);
        k = '0;
        if (r < 35 && shadow_fill > 0) begin
            k = shadow_keys[$urandom_range(shadow_fill - 1)];
            // garbage after the terminator must not change the key
            if ($urandom_range(1) == 1) begin
                ended = 1'b0;
                for (int b = 7; b >= 0; b--) begin
                    if (ended) k[8*b +: 8] = 8'($urandom);
                    else if (k[8*b +: 8] == 8'h00) ended = 1'b1;
                end
            end
        end else if (r < 90) begin
            len = $urandom_range(8);
            // narrow alphabet 'A'..'D' gives frequent shared prefixes and repeats
            for (int i = 0; i < len; i++)
                k[8*(7-i) +: 8] = (r < 80) ? 8'($urandom_range(8'h41, 8'h44))
                                           : 8'($urandom_range(1, 255));
        end else begin
            k = {$urandom, $urandom};
        end
        return k;
    endfunction

    function automatic t_table_op random_op(input t_mix mix);
        t_table_op op;
        int        r;
        int        pick;
        int        limit;
        r = $urandom_range(99);
        pick = 5;
        for (int i = 4; i >= 0; i--)
            if (r < op_cut[mix][i]) pick = i;
        if (pick == 5) op.func = 3'($urandom_range(FN_BAD_LO, FN_BAD_HI));
        else op.func = func_order[pick];
        op.key   = random_key();
        op.tag   = 8'($urandom_range(255));
        op.value = 8'($urandom_range(255));
        limit = (op.func == FN_POS_INS) ? shadow_fill + 1 : shadow_fill;
        r = $urandom_range(99);
        if (op.func == FN_LOOKUP || op.func == FN_SORTED_INS || r >= 94)
            op.slot = 7'($urandom_range(127));
        else if (r < 80)
            op.slot = 7'($urandom_range(1, (limit > 0) ? limit : 1));
        else if (r < 88)
            op.slot = '0;
        else
            op.slot = 7'(limit + 1);
        return op;
    endfunction

    task automatic add_op(input logic [FUNC_W-1:0] f, input logic [63:0] k,
                          input logic [7:0] t, input logic [7:0] v, input logic [6:0] s);
        t_dir_row row;
        row.op = '{f, k, t, v, s};
        row.typed = 1'b0;
        row.res = '0;
        dir_table.push_back(row);
    endtask

    task automatic add_checked(input logic [FUNC_W-1:0] f, input logic [63:0] k,
                               input logic [7:0] t, input logic [7:0] v,
                               input logic [6:0] s, input logic [STATUS_W-1:0] st,
                               input logic [6:0] fs, input logic [6:0] cnt,
                               input logic [63:0] rk = '0, input logic [7:0] rt = '0,
                               input logic [7:0] rv = '0);
        t_dir_row row;
        row.op = '{f, k, t, v, s};
        row.typed = 1'b1;
        row.res = '{st, fs, cnt, rk, rt, rv};
        dir_table.push_back(row);
    endtask

    // drives one word and records its expected result once accepted
    task automatic send_op(input t_table_op op, input bit typed, input t_table_res want);
        t_table_res pred;
        int         gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, op.slot, op.value, op.tag, op.key};
        s_tuser  <= op.func;
        do @(posedge clk); while (!s_tready);
        apply_table_op(op, pred);
        awaited_results.push_back(typed ? want : pred);
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
    endtask

    always @(posedge clk) begin
        t_table_res want;
        if (rst_n && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected word, status", m_tuser, '0);
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[6:0] !== want.found)
                    report_mismatch("found_slot", m_tdata[6:0], want.found);
                if (m_tdata[13:7] !== want.count)
                    report_mismatch("entry_count", m_tdata[13:7], want.count);
                if (m_tdata[77:14] !== want.key)
                    report_mismatch("key_out", m_tdata[77:14], want.key);
                if (m_tdata[85:78] !== want.tag)
                    report_mismatch("tag_out", m_tdata[85:78], want.tag);
                if (m_tdata[93:86] !== want.value)
                    report_mismatch("value_out", m_tdata[93:86], want.value);
            end
            words_checked++;
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        t_phase phases[6];
        phases[0] = '{300, 0, 0, MIX_GROW, 1'b0};
        phases[1] = '{300, 88, 0, MIX_CHURN, 1'b0};
        phases[2] = '{300, 0, 88, MIX_SHRINK, 1'b0};
        phases[3] = '{300, 18, 18, MIX_GROW, 1'b0};
        phases[4] = '{200, 0, 0, MIX_CHURN, 1'b1};
        phases[5] = '{350, 18, 18, MIX_SHRINK, 1'b0};

        // empty table: every positional access is refused
        add_checked(FN_READ, '0, 8'h00, 8'h00, 7'd1, STS_BAD_POS, 7'd0, 7'd0);
        add_checked(FN_LOOKUP, 64'h4142_0000_0000_0000, 8'h00, 8'h00, 7'd0,
                    STS_NOT_FOUND, 7'd0, 7'd0);
        add_checked(FN_REMOVE, '0, 8'h00, 8'h00, 7'd0, STS_BAD_POS, 7'd0, 7'd0);
        add_checked(FN_REMOVE, '0, 8'h00, 8'h00, 7'd1, STS_BAD_POS, 7'd0, 7'd0);
        add_checked(FN_BAD_LO, '0, 8'h00, 8'h00, 7'd1, STS_BAD_POS, 7'd0, 7'd0);
        add_checked(FN_BAD_HI, KEY_MAX, 8'hFF, 8'hFF, 7'd127, STS_BAD_POS, 7'd0, 7'd0);
        add_checked(FN_POS_INS, KEY_MAX, 8'h11, 8'h22, 7'd2, STS_BAD_POS, 7'd0, 7'd0);
        add_checked(FN_POS_INS, KEY_MAX, 8'h11, 8'h22, 7'd0, STS_BAD_POS, 7'd0, 7'd0);
        // largest and empty key
        add_checked(FN_SORTED_INS, KEY_MAX, 8'hFF, 8'hFF, 7'd0, STS_OK, 7'd1, 7'd1);
        add_checked(FN_SORTED_INS, '0, 8'h00, 8'h00, 7'd127, STS_OK, 7'd1, 7'd2);
        add_checked(FN_READ, '0, 8'h00, 8'h00, 7'd2, STS_OK, 7'd2, 7'd2,
                    KEY_MAX, 8'hFF, 8'hFF);
        add_checked(FN_READ, '0, 8'h00, 8'h00, 7'd1, STS_OK, 7'd1, 7'd2);
        add_checked(FN_SORTED_INS, KEY_MAX, 8'h12, 8'h34, 7'd0, STS_DUPLICATE, 7'd2, 7'd2);
        // bytes below an inner zero are dropped
        add_op(FN_SORTED_INS, 64'h4100_4243_4445_4647, 8'h5A, 8'hA5, 7'd0);
        add_op(FN_LOOKUP, 64'h4100_0000_0000_0000, 8'h00, 8'h00, 7'd0);
        add_op(FN_POS_INS, 64'h4243_0000_0000_0000, 8'hC3, 8'h3C, 7'd4);
        add_checked(FN_POS_INS, KEY_MAX, 8'h00, 8'h00, 7'd6, STS_BAD_POS, 7'd0, 7'd4);
        add_checked(FN_READ, '0, 8'h00, 8'h00, 7'd5, STS_BAD_POS, 7'd0, 7'd4);
        add_checked(FN_READ, '0, 8'h00, 8'h00, 7'd64, STS_BAD_POS, 7'd0, 7'd4);
        add_op(FN_REMOVE, '0, 8'h00, 8'h00, 7'd4);
        add_op(FN_LOOKUP, '0, 8'h00, 8'h00, 7'd0);
        add_op(FN_REMOVE, '0, 8'h00, 8'h00, 7'd1);
        add_checked(FN_POS_INS, KEY_MAX, 8'h00, 8'h00, 7'd127, STS_BAD_POS, 7'd0, 7'd2);
        // leading zero byte makes this the empty key
        add_op(FN_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, 8'h00, 8'h00, 7'd0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            send_op(dir_table[i].op, dir_table[i].typed, dir_table[i].res);
        drain();

        foreach (phases[p]) begin
            src_idle_pct   = phases[p].src_idle;
            sink_stall_pct = phases[p].sink_stall;
            // receiver holds off while words keep coming, so the input backs up
            if (phases[p].long_hold) hold_req++;
            repeat (phases[p].items) send_op(random_op(phases[p].mix), 1'b0, '0);
            drain();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
